>>> rtl/c3vs_pkg.sv
// shared types and constants for the streaming 3x3 correlation block
`timescale 1ns / 1ps

package c3vs_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_MATRIX_SIZE = 2'd0,
    REG_KERNEL_TOP  = 2'd1,
    REG_KERNEL_MID  = 2'd2,
    REG_KERNEL_BOT  = 2'd3
  } cfg_reg_t;

  // register field widths
  localparam int CFG_DATA_W = 7;
  localparam int SIZE_W     = 7;
  localparam int KROW_W     = 6;
  localparam int WCODE_W    = 2;

  // reset and limit values
  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd3;
  localparam logic [SIZE_W-1:0] MIN_SIDE   = 7'd3;
  localparam int WIN_COLS = 3;

  // weight codes, the other two codes mean zero
  localparam logic [WCODE_W-1:0] W_POS = 2'b01;
  localparam logic [WCODE_W-1:0] W_NEG = 2'b11;

  // weights of one window column, one code per kernel row
  typedef struct packed {
    logic [WCODE_W-1:0] top;
    logic [WCODE_W-1:0] mid;
    logic [WCODE_W-1:0] bot;
  } col_weights_t;

endpackage

>>> rtl/c3vs_line_store.sv
// one row line store with synchronous write and registered read
`timescale 1ns / 1ps

module c3vs_line_store #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/c3vs_cell.sv
// one window column cell: three taps, shifts toward the older column
`timescale 1ns / 1ps

module c3vs_cell #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          shift_en,
  input  c3vs_pkg::col_weights_t        wts,
  input  logic signed [SAMPLE_BITS-1:0] in_top,
  input  logic signed [SAMPLE_BITS-1:0] in_mid,
  input  logic signed [SAMPLE_BITS-1:0] in_bot,
  output logic signed [SAMPLE_BITS-1:0] tap_top,
  output logic signed [SAMPLE_BITS-1:0] tap_mid,
  output logic signed [SAMPLE_BITS-1:0] tap_bot,
  output logic signed [SAMPLE_BITS+1:0] col_sum
);

  import c3vs_pkg::*;

  localparam int CW = SAMPLE_BITS + 2;

  logic signed [SAMPLE_BITS-1:0] top_r;
  logic signed [SAMPLE_BITS-1:0] mid_r;
  logic signed [SAMPLE_BITS-1:0] bot_r;
  logic signed [CW-1:0]          term_top;
  logic signed [CW-1:0]          term_mid;
  logic signed [CW-1:0]          term_bot;

  // column taps, loaded from the newer neighbor
  always_ff @(posedge clk) begin
    if (shift_en) begin
      top_r <= in_top;
      mid_r <= in_mid;
      bot_r <= in_bot;
    end
  end

  assign tap_top = top_r;
  assign tap_mid = mid_r;
  assign tap_bot = bot_r;

  // weight each tap by +1, -1 or 0
  always_comb begin
    term_top = (wts.top == W_POS) ? CW'(top_r) :
               (wts.top == W_NEG) ? -CW'(top_r) : '0;
    term_mid = (wts.mid == W_POS) ? CW'(mid_r) :
               (wts.mid == W_NEG) ? -CW'(mid_r) : '0;
    term_bot = (wts.bot == W_POS) ? CW'(bot_r) :
               (wts.bot == W_NEG) ? -CW'(bot_r) : '0;
  end

  assign col_sum = term_top + term_mid + term_bot;

endmodule

>>> rtl/conv3x3_valid_stream_core.sv
// Streaming 3x3 valid-region correlation with ternary kernel weights.
//
// Input channel: in_valid / in_stall / in_sample_value, one matrix element
// per request in row-major order. Result channel: out_valid / out_stall /
// out_conv_sum / out_last_of_matrix, one request per full 3x3 window,
// (n-2)^2 per matrix, the last one flagged.
// Configuration: cfg_valid / cfg_ready / cfg_index / cfg_data, to be written
// only while the block is idle; the block itself has no check that enforces this.
// Writing the matrix size restarts the matrix. Sizes below 3 swallow samples
// without results; sizes above MAX_SIDE act as MAX_SIDE.
// Throughput: one sample per cycle while in_stall is low. An accepted sample
// passes the registered line store read and the first stage, then the window
// shift, after which the three column cells' sums are added into the output
// register.
// When the receiver stalls, the result holds in the output register, and
// one more result and one more sample are parked behind it before in_stall
// rises.
// Reset clears the counters, the pipeline valids and the output valid, sets the
// matrix size to 3 and all weights to 0. Line stores are not cleared; a
// result only reads entries written earlier in the same matrix.
`timescale 1ns / 1ps

module conv3x3_valid_stream_core #(
  parameter int MAX_SIDE    = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // sample channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample_value,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [SAMPLE_BITS+3:0]       out_conv_sum,
  output logic                                out_last_of_matrix,
  // configuration channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  c3vs_pkg::cfg_reg_t                  cfg_index,
  input  logic [c3vs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import c3vs_pkg::*;

  localparam int CNT_W  = $clog2(MAX_SIDE);
  localparam int SIDE_W = ($clog2(MAX_SIDE + 1) > SIZE_W) ? $clog2(MAX_SIDE + 1) : SIZE_W;
  localparam int SUM_W  = SAMPLE_BITS + 4;
  localparam int CS_W   = SAMPLE_BITS + 2;

  // configuration registers
  logic [SIZE_W-1:0] size_r;
  logic [KROW_W-1:0] krow_r [WIN_COLS];

  // position counters
  logic [CNT_W-1:0]  col_r, col_nxt;
  logic [CNT_W-1:0]  row_r, row_nxt;

  // first stage: sample waiting for its line store reads
  logic                          s1_valid_r;
  logic                          s1_emit_r;
  logic                          s1_last_r;
  logic signed [SAMPLE_BITS-1:0] s1_sample_r;
  logic [CNT_W-1:0]              s1_addr_r;

  // second stage: window holds a result not yet in the output register
  logic                          p_valid_r;
  logic                          p_last_r;

  // output register
  logic                          out_valid_r;
  logic signed [SUM_W-1:0]       out_sum_r;
  logic                          out_last_r;

  // handshake and flow control
  logic in_acc, size_ok, cfg_fire;
  logic out_free, s2_free, s1_free, s1_adv;

  // position decode
  logic [SIDE_W-1:0] size_ext, side_lim, side;
  logic [SIDE_W-1:0] col_ext, row_ext, c_cur, r_cur, c_inc, r_inc;
  logic              emit_cur, last_cur;

  // line store read data
  logic signed [SAMPLE_BITS-1:0] top_rd, mid_rd;

  // window chain, entry WIN_COLS feeds the newest cell
  logic signed [SAMPLE_BITS-1:0] ch_top [WIN_COLS+1];
  logic signed [SAMPLE_BITS-1:0] ch_mid [WIN_COLS+1];
  logic signed [SAMPLE_BITS-1:0] ch_bot [WIN_COLS+1];
  logic signed [CS_W-1:0]        col_sum [WIN_COLS];
  logic signed [SUM_W-1:0]       win_sum;
  logic                          unused_taps;

  // flow control, each stage moves when the one after it can take it
  assign out_free  = !out_valid_r || !out_stall;
  assign s2_free   = !p_valid_r || out_free;
  assign s1_adv    = s1_valid_r && s2_free;
  assign s1_free   = !s1_valid_r || s2_free;
  assign in_stall  = !s1_free;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign size_ok   = (size_r >= MIN_SIDE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
      for (int k = 0; k < WIN_COLS; k++) begin
        krow_r[k] <= '0;
      end
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_MATRIX_SIZE: size_r    <= SIZE_W'(cfg_data);
        REG_KERNEL_TOP:  krow_r[0] <= KROW_W'(cfg_data);
        REG_KERNEL_MID:  krow_r[1] <= KROW_W'(cfg_data);
        REG_KERNEL_BOT:  krow_r[2] <= KROW_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // effective side and current position
  always_comb begin
    size_ext = SIDE_W'(size_r);
    side_lim = SIDE_W'(MAX_SIDE);
    side     = (size_ext > side_lim) ? side_lim : size_ext;
    col_ext  = SIDE_W'(col_r);
    row_ext  = SIDE_W'(row_r);
    if (col_ext >= side || row_ext >= side) begin
      c_cur = '0;
      r_cur = '0;
    end else begin
      c_cur = col_ext;
      r_cur = row_ext;
    end
    emit_cur = (r_cur >= SIDE_W'(2)) && (c_cur >= SIDE_W'(2));
    last_cur = (r_cur == side - SIDE_W'(1)) && (c_cur == side - SIDE_W'(1));
    c_inc    = c_cur + SIDE_W'(1);
    r_inc    = r_cur + SIDE_W'(1);
    if (c_inc >= side) begin
      col_nxt = '0;
      row_nxt = (r_inc >= side) ? '0 : CNT_W'(r_inc);
    end else begin
      col_nxt = CNT_W'(c_inc);
      row_nxt = CNT_W'(r_cur);
    end
  end

  // position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cfg_fire && cfg_index == REG_MATRIX_SIZE) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc && size_ok) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line stores: a holds the previous row, b the row before it
  c3vs_line_store #(
    .DEPTH (MAX_SIDE),
    .WIDTH (SAMPLE_BITS)
  ) u_store_a (
    .clk     (clk),
    .rd_en   (in_acc && size_ok),
    .rd_addr (CNT_W'(c_cur)),
    .rd_data (mid_rd),
    .wr_en   (s1_adv),
    .wr_addr (s1_addr_r),
    .wr_data (s1_sample_r)
  );

  c3vs_line_store #(
    .DEPTH (MAX_SIDE),
    .WIDTH (SAMPLE_BITS)
  ) u_store_b (
    .clk     (clk),
    .rd_en   (in_acc && size_ok),
    .rd_addr (CNT_W'(c_cur)),
    .rd_data (top_rd),
    .wr_en   (s1_adv),
    .wr_addr (s1_addr_r),
    .wr_data (mid_rd)
  );

  // first stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc && size_ok) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // first stage payload
  always_ff @(posedge clk) begin
    if (in_acc && size_ok) begin
      s1_emit_r   <= emit_cur;
      s1_last_r   <= last_cur;
      s1_sample_r <= in_sample_value;
      s1_addr_r   <= CNT_W'(c_cur);
    end
  end

  // window chain of column cells
  assign ch_top[WIN_COLS] = top_rd;
  assign ch_mid[WIN_COLS] = mid_rd;
  assign ch_bot[WIN_COLS] = s1_sample_r;

  for (genvar k = 0; k < WIN_COLS; k++) begin : g_cell
    col_weights_t wts;
    assign wts.top = krow_r[0][2*k +: WCODE_W];
    assign wts.mid = krow_r[1][2*k +: WCODE_W];
    assign wts.bot = krow_r[2][2*k +: WCODE_W];

    c3vs_cell #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk      (clk),
      .shift_en (s1_adv),
      .wts      (wts),
      .in_top   (ch_top[k+1]),
      .in_mid   (ch_mid[k+1]),
      .in_bot   (ch_bot[k+1]),
      .tap_top  (ch_top[k]),
      .tap_mid  (ch_mid[k]),
      .tap_bot  (ch_bot[k]),
      .col_sum  (col_sum[k])
    );
  end

  // sum of the three weighted columns
  assign win_sum = SUM_W'(col_sum[0]) + SUM_W'(col_sum[1]) + SUM_W'(col_sum[2]);

  // second stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (s1_adv) begin
      p_valid_r <= s1_emit_r;
    end else if (out_free) begin
      p_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      p_last_r <= s1_last_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (p_valid_r && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_valid_r && out_free) begin
      out_sum_r  <= win_sum;
      out_last_r <= p_last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_conv_sum       = out_sum_r;
  assign out_last_of_matrix = out_last_r;

  // taps of the oldest column leave the window and are read only by its own weights
  assign unused_taps = ^{ch_top[0], ch_mid[0], ch_bot[0]};

endmodule

>>> rtl/c3vs_checker.sv
// port-level checks for the streaming 3x3 correlation block, with bind
`timescale 1ns / 1ps

module c3vs_checker #(
  parameter int SUM_W = 20
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [SUM_W-1:0] out_conv_sum,
  input logic             out_last_of_matrix
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_conv_sum)
                               && $stable(out_last_of_matrix))
    else $error("stalled result changed");

  // input is held back only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // reset empties the output
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // a sample offered to an empty output is taken
  a_take_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !out_valid |-> !in_stall)
    else $error("sample refused with empty output");

endmodule

bind conv3x3_valid_stream_core c3vs_checker #(
  .SUM_W (SAMPLE_BITS + 4)
) u_c3vs_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_conv_sum       (out_conv_sum),
  .out_last_of_matrix (out_last_of_matrix)
);

>>> verif/conv3x3_valid_stream_core_test.sv
// self-checking testbench for the streaming 3x3 valid-region correlation core
`timescale 1ns / 1ps

module conv3x3_valid_stream_core_test;
  import c3vs_pkg::*;

  localparam int SAMPLE_W      = 16;
  localparam int SUM_W         = SAMPLE_W + 4;
  localparam int SIDE_MAX      = 64;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 10;
  localparam int QUIET_LIMIT   = 2000;

  // what the stimulus plan can ask the driver to do
  typedef enum logic [1:0] {
    STEP_SAMPLE,
    STEP_WRITE,
    STEP_DRAIN,
    STEP_RATES
  } step_kind_t;

  typedef struct {
    step_kind_t                  kind;
    logic signed [SAMPLE_W-1:0]  value;
    cfg_reg_t                    reg_idx;
    logic [CFG_DATA_W-1:0]       data;
    int                          send_idle;
    int                          recv_idle;
  } step_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] conv_sum;
    logic                    is_last;
  } window_sum_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample_value;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [SUM_W-1:0]    out_conv_sum;
  logic                       out_last_of_matrix;
  logic                       cfg_valid;
  logic                       cfg_ready;
  cfg_reg_t                   cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;

  // stimulus plan and expected window sums
  step_t       plan[$];
  window_sum_t window_sums_due[$];

  // driver bookkeeping
  logic in_took;
  logic cfg_took;
  logic drain_wait;
  int   hold_left;
  int   send_idle;
  int   recv_idle;
  int   quiet_cycles;
  int   mismatches;
  int   live_samples;
  int   plan_side;

  // predicted block state
  logic [SIZE_W-1:0]          side_set;
  logic [KROW_W-1:0]          krow [3];
  logic signed [SAMPLE_W-1:0] line_a [SIDE_MAX];
  logic signed [SAMPLE_W-1:0] line_b [SIDE_MAX];
  logic signed [SAMPLE_W-1:0] win [9];
  int                         col_at;
  int                         row_at;

  conv3x3_valid_stream_core #(
    .MAX_SIDE    (SIDE_MAX),
    .SAMPLE_BITS (SAMPLE_W)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample_value    (in_sample_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_conv_sum       (out_conv_sum),
    .out_last_of_matrix (out_last_of_matrix),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // register write as seen by the predictor
  function automatic void write_setting(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_MATRIX_SIZE: begin
        side_set = data[SIZE_W-1:0];
        col_at = 0;
        row_at = 0;
      end
      REG_KERNEL_TOP: krow[0] = data[KROW_W-1:0];
      REG_KERNEL_MID: krow[1] = data[KROW_W-1:0];
      REG_KERNEL_BOT: krow[2] = data[KROW_W-1:0];
      default: ;
    endcase
  endfunction

  // shift one sample into the window and queue the sum it completes
  function automatic void slide_window(logic signed [SAMPLE_W-1:0] smp);
    int n;
    int c;
    int r;
    int x;
    int y;
    int acc;
    logic [WCODE_W-1:0] code;
    logic signed [SAMPLE_W-1:0] up2;
    logic signed [SAMPLE_W-1:0] up1;
    window_sum_t res;
    n = side_set;
    if (n < MIN_SIDE) return;
    if (n > SIDE_MAX) n = SIDE_MAX;
    if (col_at >= n || row_at >= n) begin
      col_at = 0;
      row_at = 0;
    end
    c = col_at;
    r = row_at;
    up2 = line_b[c];
    up1 = line_a[c];
    line_b[c] = up1;
    line_a[c] = smp;
    for (x = 0; x < 3; x++) begin
      win[x*3]   = win[x*3+1];
      win[x*3+1] = win[x*3+2];
    end
    win[2] = up2;
    win[5] = up1;
    win[8] = smp;
    col_at = c + 1;
    if (col_at >= n) begin
      col_at = 0;
      row_at = r + 1;
      if (row_at >= n) row_at = 0;
    end
    if (r < 2 || c < 2) return;
    acc = 0;
    for (x = 0; x < 3; x++) begin
      for (y = 0; y < 3; y++) begin
        code = krow[x][2*y +: WCODE_W];
        if (code == W_POS) acc += win[x*3+y];
        else if (code == W_NEG) acc -= win[x*3+y];
      end
    end
    res.conv_sum = acc[SUM_W-1:0];
    res.is_last = (r == n - 1) && (c == n - 1);
    window_sums_due.push_back(res);
  endfunction

  // plan building
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(15))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return '1;
      default: return r[SAMPLE_W-1:0];
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_kernel();
    case ($urandom_range(5))
      0: return {1'($urandom_range(1)), 6'h00};
      1: return {1'($urandom_range(1)), 6'h3f};
      default: return CFG_DATA_W'($urandom_range(127));
    endcase
  endfunction

  task automatic push_sample(logic signed [SAMPLE_W-1:0] v);
    step_t s;
    s.kind = STEP_SAMPLE;
    s.value = v;
    plan.push_back(s);
    if (plan_side >= MIN_SIDE) live_samples++;
  endtask

  task automatic push_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    step_t s;
    s.kind = STEP_WRITE;
    s.reg_idx = idx;
    s.data = data;
    plan.push_back(s);
    if (idx == REG_MATRIX_SIZE) plan_side = data;
  endtask

  task automatic push_drain();
    step_t s;
    s.kind = STEP_DRAIN;
    plan.push_back(s);
  endtask

  task automatic push_rates(int send_pct, int recv_pct);
    step_t s;
    s.kind = STEP_RATES;
    s.send_idle = send_pct;
    s.recv_idle = recv_pct;
    plan.push_back(s);
  endtask

  task automatic feed(int count);
    repeat (count) push_sample(pick_sample());
  endtask

  // settings change only once the block has gone quiet
  task automatic reconfigure(int side);
    push_drain();
    if ($urandom_range(3) != 0) begin
      push_write(REG_KERNEL_TOP, pick_kernel());
      push_write(REG_KERNEL_MID, pick_kernel());
      push_write(REG_KERNEL_BOT, pick_kernel());
    end
    push_write(REG_MATRIX_SIZE, CFG_DATA_W'(side));
  endtask

  task automatic plan_phase(int big_side, int quota);
    int start;
    int eff;
    int n;
    int sel;
    int reps;
    int cut;
    start = live_samples;
    // a few rows at a wide setting reach every line store column
    eff = (big_side > SIDE_MAX) ? SIDE_MAX : big_side;
    reconfigure(big_side);
    feed(2 * eff + $urandom_range(3, eff));
    while (live_samples - start < quota) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        // sizes below three swallow samples
        reconfigure($urandom_range(2));
        feed($urandom_range(1, 4));
      end else begin
        n = (sel < 80) ? $urandom_range(3, 8) : $urandom_range(9, 16);
        reps = (n > 8) ? 1 : $urandom_range(1, 3);
        reconfigure(n);
        feed(n * n * reps);
        // pause in the middle of a matrix until every sum is out
        if ($urandom_range(4) == 0) begin
          cut = $urandom_range(1, n * n - 1);
          feed(cut);
          push_drain();
          feed(n * n - cut);
        end
        // matrix cut off by the next size write
        if ($urandom_range(3) == 0) feed($urandom_range(1, n * n - 1));
      end
    end
  endtask

  // driver: inputs change on the falling edge
  always @(negedge clk) begin : drive_requests
    logic                       nxt_valid;
    logic                       nxt_cfg;
    logic                       nxt_stall;
    logic signed [SAMPLE_W-1:0] nxt_value;
    cfg_reg_t                   nxt_idx;
    logic [CFG_DATA_W-1:0]      nxt_data;
    step_t                      step;
    nxt_valid = in_valid && !in_took;
    nxt_cfg = cfg_valid && !cfg_took;
    nxt_value = in_sample_value;
    nxt_idx = cfg_index;
    nxt_data = cfg_data;
    nxt_stall = 1'b0;
    if (rst_n) begin
      nxt_stall = ($urandom_range(99) < recv_idle);
      if (!nxt_valid && !nxt_cfg) begin
        if (hold_left != 0) begin
          hold_left--;
        end else if (drain_wait) begin
          if (window_sums_due.size() == 0) begin
            drain_wait = 1'b0;
            hold_left = SETTLE_CYCLES;
          end
        end else if (plan.size() != 0) begin
          step = plan[0];
          case (step.kind)
            STEP_SAMPLE: begin
              if ($urandom_range(99) >= send_idle) begin
                void'(plan.pop_front());
                nxt_valid = 1'b1;
                nxt_value = step.value;
              end
            end
            STEP_WRITE: begin
              void'(plan.pop_front());
              nxt_cfg = 1'b1;
              nxt_idx = step.reg_idx;
              nxt_data = step.data;
            end
            STEP_DRAIN: begin
              void'(plan.pop_front());
              drain_wait = 1'b1;
            end
            STEP_RATES: begin
              void'(plan.pop_front());
              send_idle = step.send_idle;
              recv_idle = step.recv_idle;
            end
            default: ;
          endcase
        end
      end
    end
    in_valid <= nxt_valid;
    in_sample_value <= nxt_value;
    cfg_valid <= nxt_cfg;
    cfg_index <= nxt_idx;
    cfg_data <= nxt_data;
    out_stall <= nxt_stall;
  end

  // monitor: requests and results sampled on the rising edge
  always @(posedge clk) begin : watch_results
    window_sum_t want;
    logic        out_took;
    in_took = 1'b0;
    cfg_took = 1'b0;
    out_took = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        in_took = 1'b1;
        slide_window(in_sample_value);
      end
      if (cfg_valid && cfg_ready) begin
        cfg_took = 1'b1;
        write_setting(cfg_index, cfg_data);
      end
      if (out_valid && !out_stall) begin
        out_took = 1'b1;
        if (window_sums_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: expected none, actual sum %0d last %0b",
                   $time, out_conv_sum, out_last_of_matrix);
        end else begin
          want = window_sums_due.pop_front();
          if (out_conv_sum !== want.conv_sum) begin
            mismatches++;
            $display("%0t: conv_sum mismatch: expected %0d, actual %0d",
                     $time, want.conv_sum, out_conv_sum);
          end
          if (out_last_of_matrix !== want.is_last) begin
            mismatches++;
            $display("%0t: last_of_matrix mismatch: expected %0b, actual %0b",
                     $time, want.is_last, out_last_of_matrix);
          end
        end
      end
      if (in_took || cfg_took || out_took) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // watchdog on cycles with no request accepted anywhere
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk);
    $display("watchdog: nothing accepted for %0d cycles", QUIET_LIMIT);
    $display("** conv3x3_valid_stream_core: FAILED **");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample_value = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_MATRIX_SIZE;
    cfg_data = '0;
    in_took = 1'b0;
    cfg_took = 1'b0;
    drain_wait = 1'b0;
    hold_left = 0;
    send_idle = 0;
    recv_idle = 0;
    quiet_cycles = 0;
    mismatches = 0;
    live_samples = 0;
    plan_side = SIZE_RESET;
    // predictor reset state
    side_set = SIZE_RESET;
    col_at = 0;
    row_at = 0;
    foreach (krow[i]) krow[i] = '0;
    foreach (win[i]) win[i] = '0;
    foreach (line_a[i]) begin
      line_a[i] = '0;
      line_b[i] = '0;
    end

    // directed: most negative sum, then most positive
    push_rates(23, 73);
    push_write(REG_MATRIX_SIZE, 7'd3);
    push_write(REG_KERNEL_TOP, 7'h15);
    push_write(REG_KERNEL_MID, 7'h15);
    push_write(REG_KERNEL_BOT, 7'h15);
    repeat (9) push_sample(16'sh8000);
    push_drain();
    push_write(REG_KERNEL_TOP, 7'h7f);
    push_write(REG_KERNEL_MID, 7'h7f);
    push_write(REG_KERNEL_BOT, 7'h7f);
    repeat (9) push_sample(16'sh8000);
    // directed: small sizes take samples and give nothing
    push_drain();
    push_write(REG_MATRIX_SIZE, 7'd0);
    push_sample(16'sh7fff);
    push_sample('0);
    push_drain();
    push_write(REG_MATRIX_SIZE, 7'd2);
    push_sample('1);
    push_sample(16'sh7fff);

    // random phases with changing idle rates
    plan_phase(SIDE_MAX, 380);
    push_rates(73, 23);
    plan_phase(127, 400);
    push_rates(0, 0);
    plan_phase(SIDE_MAX + 1, 400);
    push_drain();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // run until the plan is spent and every sum is out
    @(posedge clk);
    #1;
    while (plan.size() != 0 || in_valid || cfg_valid || drain_wait || hold_left != 0 ||
           window_sums_due.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    #1;
    if (mismatches == 0 && window_sums_due.size() == 0) begin
      $display("** conv3x3_valid_stream_core: PASSED **");
    end else begin
      $display("** conv3x3_valid_stream_core: FAILED **");
    end
    $finish;
  end

endmodule
